FILE: design/drive_command_to_pwm_frame_defines.svh
// Assertion macros used by the checker file.
`ifndef DRIVE_COMMAND_TO_PWM_FRAME_DEFINES_SVH
`define DRIVE_COMMAND_TO_PWM_FRAME_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dcpf_pkg.sv
// Types and constants of the drive command to PWM frame encoder.
package dcpf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 3'd7;

    // Register reset values
    localparam logic [14:0] RST_MAX_SPEED  = 15'd768;
    localparam logic [14:0] RST_MAX_STEER  = 15'd3277;
    localparam logic [15:0] RST_ESC_MIN    = 16'd4000;
    localparam logic [15:0] RST_ESC_MAX    = 16'd6000;
    localparam logic [15:0] RST_STEER_MIN  = 16'd4000;
    localparam logic [15:0] RST_STEER_MAX  = 16'd6000;
    localparam logic [15:0] RST_NEUTRAL    = 16'd5000;
    localparam logic [15:0] RST_START_CODE = 16'd1;

    // Coefficients, unsigned Q.16
    localparam logic [28:0] COEF_BASE  = 29'd336771082;   // 5138.7189
    localparam logic [23:0] COEF_LIN   = 24'd13502421;    // 206.0306
    localparam logic [21:0] COEF_SQR   = 22'd2664307;     // 40.6541
    localparam logic [22:0] COEF_STEER = 23'd5632404;     // 1.5 * 180 / pi

    localparam logic [15:0] STOP_ESC = 16'd5138;
    localparam logic [7:0]  SYNC0    = 8'hFF;
    localparam logic [7:0]  SYNC1    = 8'hFE;

    // Byte positions within the frame
    localparam logic [2:0] BYTE_SYNC0    = 3'd0;
    localparam logic [2:0] BYTE_SYNC1    = 3'd1;
    localparam logic [2:0] BYTE_STEER_HI = 3'd2;
    localparam logic [2:0] BYTE_STEER_LO = 3'd3;
    localparam logic [2:0] BYTE_ESC_HI   = 3'd4;
    localparam logic [2:0] BYTE_ESC_LO   = 3'd5;
    localparam logic [2:0] BYTE_DRV_HI   = 3'd6;
    localparam logic [2:0] BYTE_DRV_LO   = 3'd7;

    typedef struct packed {
        logic signed [15:0] speed_cmd;
        logic signed [15:0] steer_cmd;
        logic [15:0]        drive_cmd;
    } in_t;

    typedef struct packed {
        logic [7:0]         frame_byte;
        logic               last_byte;
        logic [14:0]        applied_speed;
        logic signed [15:0] applied_steer;
        logic               started;
    } out_t;

    typedef struct packed {
        logic [14:0] speed_limit;
        logic [14:0] max_steer;
        logic [15:0] esc_min;
        logic [15:0] esc_max;
        logic [15:0] steer_min;
        logic [15:0] steer_max;
        logic [15:0] neutral;
        logic [15:0] start_code;
    } cfg_t;

    // Finished pulse values of one command, ready for framing
    typedef struct packed {
        logic [15:0]        esc;
        logic [15:0]        steer;
        logic [15:0]        drv;
        logic [14:0]        app_spd;
        logic signed [15:0] app_ang;
        logic               started;
    } pulse_t;

endpackage

FILE: design/dcpf_cfg.sv
// Configuration register file of the PWM frame encoder.
module dcpf_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dcpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dcpf_pkg::cfg_t                   cfg
);

    dcpf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_limit <= dcpf_pkg::RST_MAX_SPEED;
            cfg_reg.max_steer   <= dcpf_pkg::RST_MAX_STEER;
            cfg_reg.esc_min     <= dcpf_pkg::RST_ESC_MIN;
            cfg_reg.esc_max     <= dcpf_pkg::RST_ESC_MAX;
            cfg_reg.steer_min   <= dcpf_pkg::RST_STEER_MIN;
            cfg_reg.steer_max   <= dcpf_pkg::RST_STEER_MAX;
            cfg_reg.neutral     <= dcpf_pkg::RST_NEUTRAL;
            cfg_reg.start_code  <= dcpf_pkg::RST_START_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcpf_pkg::REG_MAX_SPEED:  cfg_reg.speed_limit <= cfg_data[14:0];
                dcpf_pkg::REG_MAX_STEER:  cfg_reg.max_steer   <= cfg_data[14:0];
                dcpf_pkg::REG_ESC_MIN:    cfg_reg.esc_min     <= cfg_data;
                dcpf_pkg::REG_ESC_MAX:    cfg_reg.esc_max     <= cfg_data;
                dcpf_pkg::REG_STEER_MIN:  cfg_reg.steer_min   <= cfg_data;
                dcpf_pkg::REG_STEER_MAX:  cfg_reg.steer_max   <= cfg_data;
                dcpf_pkg::REG_NEUTRAL:    cfg_reg.neutral     <= cfg_data;
                dcpf_pkg::REG_START_CODE: cfg_reg.start_code  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/dcpf_calc.sv
// Six-stage pipeline from command to clamped ESC and steering pulse values.
module dcpf_calc (
    input  logic             clk,
    input  logic             rst_n,
    input  dcpf_pkg::cfg_t   cfg,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  dcpf_pkg::in_t    cmd,
    output logic             pulse_valid,
    input  logic             pulse_ready,
    output dcpf_pkg::pulse_t pulse
);

    localparam int NSTAGE = 6;

    // Values carried unchanged along the pipe
    typedef struct packed {
        logic               go;
        logic [15:0]        drv;
        logic [14:0]        app_spd;
        logic signed [15:0] app_ang;
    } side_t;

    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] adv;
    side_t           side_reg [1:NSTAGE-1];

    // Stage ready chain: a stage loads when empty or when its content moves on
    always_comb
    begin
        adv[NSTAGE] = !vld_reg[NSTAGE] || pulse_ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign cmd_ready   = adv[1];
    assign pulse_valid = vld_reg[NSTAGE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= cmd_valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: start check and input clamps
    logic               s1_go;
    logic [14:0]        s1_spd;
    logic signed [15:0] s1_ang;
    logic signed [15:0] s1_lim_pos;
    logic signed [15:0] s1_lim_neg;
    side_t              s1_next;

    always_comb
    begin
        s1_go      = (cmd.drive_cmd == cfg.start_code);
        s1_lim_pos = $signed({1'b0, cfg.max_steer});
        s1_lim_neg = 16'sd0 - s1_lim_pos;
        if (cmd.speed_cmd[15])
        begin
            s1_spd = '0;
        end
        else if (cmd.speed_cmd[14:0] > cfg.speed_limit)
        begin
            s1_spd = cfg.speed_limit;
        end
        else
        begin
            s1_spd = cmd.speed_cmd[14:0];
        end
        if (cmd.steer_cmd > s1_lim_pos)
        begin
            s1_ang = s1_lim_pos;
        end
        else if (cmd.steer_cmd < s1_lim_neg)
        begin
            s1_ang = s1_lim_neg;
        end
        else
        begin
            s1_ang = cmd.steer_cmd;
        end
        s1_next.go      = s1_go;
        s1_next.drv     = cmd.drive_cmd;
        s1_next.app_spd = s1_go ? s1_spd : 15'd0;
        s1_next.app_ang = s1_go ? s1_ang : 16'sd0;
    end

    // Side values move with their stage; stage 6 keeps them in the pulse record
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            side_reg[1] <= s1_next;
        end
        for (int k = 2; k < NSTAGE; k++)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- stage 2: first products
    logic [29:0] sq_reg,  sq_next;
    logic [38:0] lin_reg, lin_next;
    logic [37:0] pm_reg,  pm_next;
    logic        neg_reg;
    logic [14:0] s2_mag;

    always_comb
    begin
        s2_mag   = side_reg[1].app_ang[15] ? 15'(16'sd0 - side_reg[1].app_ang)
                                           : side_reg[1].app_ang[14:0];
        sq_next  = {15'd0, side_reg[1].app_spd} * {15'd0, side_reg[1].app_spd};
        lin_next = {24'd0, side_reg[1].app_spd} * {15'd0, dcpf_pkg::COEF_LIN};
        pm_next  = {23'd0, s2_mag} * {15'd0, dcpf_pkg::COEF_STEER};
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sq_reg      <= sq_next;
            lin_reg     <= lin_next;
            pm_reg      <= pm_next;
            neg_reg     <= side_reg[1].app_ang[15];
        end
    end

    // ---------------- stage 3: square term, raw steering pulse
    logic [51:0]        sqp_reg, sqp_next;
    logic [38:0]        lin3_reg;
    logic signed [17:0] st_reg, st_next;
    logic [8:0]         s3_q;

    always_comb
    begin
        s3_q     = pm_reg[37:29];
        sqp_next = {22'd0, sq_reg} * {30'd0, dcpf_pkg::COEF_SQR};
        // negative angle steers toward higher pulse values
        st_next  = neg_reg ? $signed({2'b00, cfg.neutral} + {9'd0, s3_q})
                           : $signed({2'b00, cfg.neutral} - {9'd0, s3_q});
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sqp_reg     <= sqp_next;
            lin3_reg    <= lin_reg;
            st_reg      <= st_next;
        end
    end

    // ---------------- stage 4: ESC polynomial in Q.32, steering clamp
    logic signed [55:0] sum_reg, sum_next;
    logic [15:0]        stc_reg, stc_next;
    logic signed [17:0] s4_hi, s4_lo, s4_t;

    always_comb
    begin
        sum_next = $signed({11'd0, dcpf_pkg::COEF_BASE, 16'd0}
                           + {9'd0, lin3_reg, 8'd0}
                           - {4'd0, sqp_reg});
        s4_hi = $signed({2'b00, cfg.steer_max});
        s4_lo = $signed({2'b00, cfg.steer_min});
        s4_t  = (st_reg > s4_hi) ? s4_hi : st_reg;
        s4_t  = (s4_t < s4_lo) ? s4_lo : s4_t;
        stc_next = s4_t[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            sum_reg     <= sum_next;
            stc_reg     <= stc_next;
        end
    end

    // ---------------- stage 5: truncate toward zero
    logic signed [23:0] e_reg, e_next;
    logic [15:0]        stc5_reg;

    always_comb
    begin
        e_next = sum_reg[55:32] + {23'd0, sum_reg[55] & (|sum_reg[31:0])};
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            e_reg       <= e_next;
            stc5_reg    <= stc_reg;
        end
    end

    // ---------------- stage 6: ESC clamp, stop frame selection
    dcpf_pkg::pulse_t   pulse_reg, pulse_next;
    logic signed [23:0] s6_hi, s6_lo, s6_t;

    always_comb
    begin
        s6_hi = $signed({8'd0, cfg.esc_max});
        s6_lo = $signed({8'd0, cfg.esc_min});
        s6_t  = (e_reg > s6_hi) ? s6_hi : e_reg;
        s6_t  = (s6_t < s6_lo) ? s6_lo : s6_t;
        pulse_next.esc     = side_reg[5].go ? s6_t[15:0] : dcpf_pkg::STOP_ESC;
        pulse_next.steer   = side_reg[5].go ? stc5_reg : cfg.neutral;
        pulse_next.drv     = side_reg[5].drv;
        pulse_next.app_spd = side_reg[5].app_spd;
        pulse_next.app_ang = side_reg[5].app_ang;
        pulse_next.started = side_reg[5].go;
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            pulse_reg   <= pulse_next;
        end
    end

    assign pulse = pulse_reg;

endmodule

FILE: design/dcpf_ser.sv
// Frame serializer: one pulse record in, eight frame bytes out.
module dcpf_ser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pulse_valid,
    output logic             pulse_ready,
    input  dcpf_pkg::pulse_t pulse,
    output logic             frame_valid,
    input  logic             frame_ready,
    output dcpf_pkg::out_t   frame
);

    dcpf_pkg::pulse_t rec_reg;
    logic [2:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             last;
    logic             take;
    logic             send;

    assign last        = (cnt_reg == dcpf_pkg::BYTE_DRV_LO);
    assign send        = busy_reg && frame_ready;
    assign pulse_ready = !busy_reg || (frame_ready && last);
    assign take        = pulse_valid && pulse_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (send)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            cnt_next  = dcpf_pkg::BYTE_SYNC0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rec_reg <= pulse;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            dcpf_pkg::BYTE_SYNC0:    frame.frame_byte = dcpf_pkg::SYNC0;
            dcpf_pkg::BYTE_SYNC1:    frame.frame_byte = dcpf_pkg::SYNC1;
            dcpf_pkg::BYTE_STEER_HI: frame.frame_byte = rec_reg.steer[15:8];
            dcpf_pkg::BYTE_STEER_LO: frame.frame_byte = rec_reg.steer[7:0];
            dcpf_pkg::BYTE_ESC_HI:   frame.frame_byte = rec_reg.esc[15:8];
            dcpf_pkg::BYTE_ESC_LO:   frame.frame_byte = rec_reg.esc[7:0];
            dcpf_pkg::BYTE_DRV_HI:   frame.frame_byte = rec_reg.drv[15:8];
            default:                 frame.frame_byte = rec_reg.drv[7:0];
        endcase
        frame.last_byte     = last;
        frame.applied_speed = rec_reg.app_spd;
        frame.applied_steer = rec_reg.app_ang;
        frame.started       = rec_reg.started;
    end

    assign frame_valid = busy_reg;

endmodule

FILE: design/drive_command_to_pwm_frame.sv
// Top level of the drive command to PWM frame encoder.
//
// Usage:
//   cmd channel (cmd_valid / cmd_ready / cmd): one drive command per transfer,
//   carrying speed (Q8.8), steering angle (Q2.13) and the drive command code.
//   frame channel (frame_valid / frame_ready / frame): eight transfers per
//   command, the frame bytes FF, FE, steering hi/lo, ESC hi/lo, drive hi/lo,
//   with last_byte set on the eighth. Applied speed, applied angle and the
//   started flag repeat on all eight bytes.
//   cfg port (cfg_we / cfg_index / cfg_data): single-cycle register writes,
//   no read-back; write only while no command is in flight.
// Path: an accepted command passes the six arithmetic stages and is then
//   loaded into the serializer, which then shows its first byte.
// Throughput: the sustained command rate is set by the serializer, which
//   emits one byte per cycle while frame_ready is high; the six-stage pipe
//   takes a command every cycle unless full, and buffers up to six commands.
// Reset: rst_n clears the pipe and serializer and loads the register
//   defaults; cmd_ready is high once reset is released.
// Stall: when frame_ready is low the current byte holds; the pipe keeps
//   accepting until all stages are full, then cmd_ready drops.
module drive_command_to_pwm_frame (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  dcpf_pkg::in_t                    cmd,
    output logic                             frame_valid,
    input  logic                             frame_ready,
    output dcpf_pkg::out_t                   frame,
    input  logic                             cfg_we,
    input  logic [dcpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dcpf_pkg::cfg_t   cfg;
    dcpf_pkg::pulse_t pulse;
    logic             pulse_valid;
    logic             pulse_ready;

    // Register file
    dcpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Clamps, polynomial and steering map, one stage per major operation
    dcpf_calc u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pulse       (pulse)
    );

    // Byte serializer; takes the next record when idle or on its eighth byte transfer
    dcpf_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pulse       (pulse),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

endmodule

FILE: design/dcpf_checker.sv
// Port-level checker for the PWM frame encoder, bound to the top level.
`include "drive_command_to_pwm_frame_defines.svh"

module dcpf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_ready,
    input  logic                             frame_valid,
    input  logic                             frame_ready,
    input  dcpf_pkg::out_t                   frame
);

    `DCPF_ASSERT_NEXT(a_frame_hold, clk, rst_n,
        frame_valid && !frame_ready, frame_valid && $stable(frame),
        "stalled frame byte changed")

    `DCPF_ASSERT_NEXT(a_frame_burst, clk, rst_n,
        frame_valid && frame_ready && !frame.last_byte, frame_valid,
        "gap inside a frame")

    `DCPF_ASSERT_NOW(a_stop_zero, clk, rst_n,
        frame_valid && !frame.started,
        frame.applied_speed == 15'd0 && frame.applied_steer == 16'sd0,
        "stop frame with nonzero applied values")

    `DCPF_ASSERT_NOW(a_idle_ready, clk, rst_n, !frame_valid, cmd_ready,
        "command refused while output idle")

endmodule

bind drive_command_to_pwm_frame dcpf_checker u_dcpf_checker (.*);

FILE: verif/drive_command_to_pwm_frame_tb.sv
// Self-checking testbench for the drive command to PWM frame encoder.
module drive_command_to_pwm_frame_tb;
    import dcpf_pkg::*;

    // Coefficients of the pulse mapping, unsigned Q.16
    localparam longint ESC_OFFSET_Q16 = 336771082;  // 5138.7189
    localparam longint ESC_LIN_Q16    = 13502421;   // 206.0306
    localparam longint ESC_SQR_Q16    = 2664307;    // 40.6541
    localparam longint STEER_GAIN_Q16 = 5632404;    // 1.5 * 180 / pi
    localparam logic [15:0] STOP_PULSE = 16'd5138;

    // Cycles with no transfer on either channel before the run is called hung
    localparam int IDLE_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    in_t         cmd = '0;
    logic        frame_valid;
    logic        frame_ready = 1'b0;
    out_t        frame;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the register file, kept in step with every write
    logic [14:0] lim_speed;
    logic [14:0] lim_steer;
    logic [15:0] esc_lo;
    logic [15:0] esc_hi;
    logic [15:0] steer_lo;
    logic [15:0] steer_hi;
    logic [15:0] steer_center;
    logic [15:0] go_code;

    // Frame bytes still owed by the block, oldest first
    out_t expected_bytes [$];
    int   error_count = 0;
    int   idle_cycles = 0;
    // When set, neither side inserts gaps
    bit   back_to_back = 1'b0;

    drive_command_to_pwm_frame u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        // Upper bound first, so with inverted limits the lower one wins
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v;
    endfunction

    function automatic longint shr_toward_zero(longint v, int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    // Work out the eight frame bytes one command produces and queue them.
    task automatic push_expected_frame(in_t c);
        longint      spd;
        longint      ang;
        longint      app_spd;
        longint      app_ang;
        longint      esc_sum;
        longint      st;
        logic [15:0] esc_pw;
        logic [15:0] steer_pw;
        logic        go;
        logic [7:0]  fb [0:7];
        out_t        o;
        spd = $signed(c.speed_cmd);
        ang = $signed(c.steer_cmd);
        go = (c.drive_cmd == go_code);
        app_spd = 0;
        app_ang = 0;
        if (go)
        begin
            app_spd = clamp_range(spd, 0, longint'(lim_speed));
            app_ang = clamp_range(ang, -longint'(lim_steer), longint'(lim_steer));
            // ESC polynomial in Q.32, exact, then cut toward zero
            esc_sum = ESC_OFFSET_Q16 * 65536 + ESC_LIN_Q16 * app_spd * 256
                      - ESC_SQR_Q16 * app_spd * app_spd;
            esc_pw = 16'(clamp_range(shr_toward_zero(esc_sum, 32),
                                     longint'(esc_lo), longint'(esc_hi)));
            // Steering product is Q.29
            st = longint'(steer_center) + shr_toward_zero(-(STEER_GAIN_Q16 * app_ang), 29);
            steer_pw = 16'(clamp_range(st, longint'(steer_lo), longint'(steer_hi)));
        end
        else
        begin
            // Stop frame: fixed ESC value, neutral steering, no limit clamp
            esc_pw = STOP_PULSE;
            steer_pw = steer_center;
        end
        fb[BYTE_SYNC0]    = SYNC0;
        fb[BYTE_SYNC1]    = SYNC1;
        fb[BYTE_STEER_HI] = steer_pw[15:8];
        fb[BYTE_STEER_LO] = steer_pw[7:0];
        fb[BYTE_ESC_HI]   = esc_pw[15:8];
        fb[BYTE_ESC_LO]   = esc_pw[7:0];
        fb[BYTE_DRV_HI]   = c.drive_cmd[15:8];
        fb[BYTE_DRV_LO]   = c.drive_cmd[7:0];
        for (int k = 0; k < 8; k++)
        begin
            o.frame_byte    = fb[k];
            o.last_byte     = (k == 7);
            o.applied_speed = 15'(app_spd);
            o.applied_steer = 16'(app_ang);
            o.started       = go;
            expected_bytes.push_back(o);
        end
    endtask

    // One command transfer. Called at a rising edge; returns at the edge
    // where the command was taken, with valid still high.
    task automatic send_drive_command(logic [15:0] spd, logic [15:0] ang, logic [15:0] drv);
        int  gap;
        in_t c;
        c.speed_cmd = spd;
        c.steer_cmd = ang;
        c.drive_cmd = drv;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        push_expected_frame(c);
    endtask

    // Drop valid and let every owed byte drain, plus a little slack.
    task automatic wait_frames_done();
        cmd_valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MAX_SPEED:  lim_speed = data[14:0];
            REG_MAX_STEER:  lim_steer = data[14:0];
            REG_ESC_MIN:    esc_lo = data;
            REG_ESC_MAX:    esc_hi = data;
            REG_STEER_MIN:  steer_lo = data;
            REG_STEER_MAX:  steer_hi = data;
            REG_NEUTRAL:    steer_center = data;
            REG_START_CODE: go_code = data;
            default: ;
        endcase
    endtask

    // Speed sweep at reset settings: negative, zero, around the clamp, top.
    task automatic test_speed_extremes();
        logic [15:0] speeds [10] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h00FF,
                                     16'h0100, 16'd767, 16'd768, 16'd769, 16'h7FFF};
        foreach (speeds[i])
        begin
            send_drive_command(speeds[i], 16'h0000, go_code);
        end
    endtask

    // Steering sweep at reset settings, both signs, on and off the limit.
    task automatic test_steer_extremes();
        logic [15:0] angles [8] = '{16'h8000, -16'sd3278, -16'sd3277, 16'hFFFF,
                                    16'h0001, 16'd3277, 16'd3278, 16'h7FFF};
        foreach (angles[i])
        begin
            send_drive_command(16'd512, angles[i], go_code);
        end
    endtask

    // Drive codes that differ from the start code give stop frames.
    task automatic test_not_started();
        send_drive_command(16'($urandom), 16'($urandom), 16'h0000);
        send_drive_command(16'($urandom), 16'($urandom), 16'hFFFF);
        send_drive_command(16'($urandom), 16'($urandom), 16'h8000);
    endtask

    // Widest limits. 15-bit registers get all ones to check the top bit drops.
    task automatic test_wide_limits();
        wait_frames_done();
        write_reg(REG_MAX_SPEED, 16'hFFFF);
        write_reg(REG_MAX_STEER, 16'hFFFF);
        write_reg(REG_ESC_MIN, 16'h0000);
        write_reg(REG_ESC_MAX, 16'hFFFF);
        write_reg(REG_STEER_MIN, 16'h0000);
        write_reg(REG_STEER_MAX, 16'hFFFF);
        write_reg(REG_NEUTRAL, 16'h0000);
        write_reg(REG_START_CODE, 16'hFFFF);
        send_drive_command(16'h7FFF, 16'h7FFF, 16'hFFFF);   // steering below zero
        send_drive_command(16'h0080, 16'h8000, 16'hFFFF);
        wait_frames_done();
        write_reg(REG_NEUTRAL, 16'hFFFF);
        send_drive_command(16'h4000, 16'h8000, 16'hFFFF);   // steering past 65535
        send_drive_command(16'h8000, 16'h7FFF, 16'hFFFF);
        send_drive_command(16'h1234, 16'h4321, 16'h0001);   // stop with top neutral
    endtask

    // Minimum above maximum on both pulses, and zero angle and speed limits.
    task automatic test_inverted_limits();
        wait_frames_done();
        write_reg(REG_MAX_SPEED, 16'h0000);
        write_reg(REG_MAX_STEER, 16'h0000);
        write_reg(REG_ESC_MIN, 16'd6000);
        write_reg(REG_ESC_MAX, 16'd4000);
        write_reg(REG_STEER_MIN, 16'd6000);
        write_reg(REG_STEER_MAX, 16'd4000);
        write_reg(REG_NEUTRAL, 16'd5000);
        write_reg(REG_START_CODE, 16'h0000);
        send_drive_command(16'h0300, 16'h1000, 16'h0000);
        send_drive_command(16'h8000, 16'h8000, 16'h0000);
        send_drive_command(16'h0300, 16'h1000, 16'h0002);
    endtask

    task automatic load_random_settings();
        logic [15:0] lo;
        logic [15:0] hi;
        case ($urandom_range(0, 3))
            0:       write_reg(REG_MAX_SPEED, 16'h0000);
            1:       write_reg(REG_MAX_SPEED, 16'hFFFF);
            2:       write_reg(REG_MAX_SPEED, 16'($urandom_range(0, 3000)));
            default: write_reg(REG_MAX_SPEED, 16'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(REG_MAX_STEER, 16'h0000);
            1:       write_reg(REG_MAX_STEER, 16'hFFFF);
            2:       write_reg(REG_MAX_STEER, 16'($urandom_range(0, 6000)));
            default: write_reg(REG_MAX_STEER, 16'($urandom));
        endcase
        // Mostly sane windows around the neutral point; sometimes anything
        lo = 16'($urandom_range(3000, 5000));
        hi = lo + 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0)
        begin
            lo = 16'($urandom);
            hi = 16'($urandom);
        end
        write_reg(REG_ESC_MIN, lo);
        write_reg(REG_ESC_MAX, hi);
        lo = 16'($urandom_range(3000, 5000));
        hi = lo + 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0)
        begin
            lo = 16'($urandom);
            hi = 16'($urandom);
        end
        write_reg(REG_STEER_MIN, lo);
        write_reg(REG_STEER_MAX, hi);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_NEUTRAL, 16'($urandom));
        end
        else
        begin
            write_reg(REG_NEUTRAL, 16'($urandom_range(3000, 7000)));
        end
        write_reg(REG_START_CODE, 16'($urandom));
    endtask

    // Mostly started commands; speed and angle are each drawn inside their limits half the time.
    task automatic send_random_command();
        logic [15:0] spd;
        logic [15:0] ang;
        logic [15:0] drv;
        spd = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, lim_speed));
        if ($urandom_range(0, 1))
        begin
            ang = 16'($urandom);
        end
        else
        begin
            ang = 16'(int'($urandom_range(0, 2 * int'(lim_steer))) - int'(lim_steer));
        end
        drv = ($urandom_range(0, 3) != 0) ? go_code : 16'($urandom);
        send_drive_command(spd, ang, drv);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_frames_done();
            load_random_settings();
            back_to_back = (phase == 2);
            for (int i = 0; i < 22; i++)
            begin
                // Hold off the sender once until the pipe is empty
                if (phase == 1 && i == 11)
                begin
                    wait_frames_done();
                end
                send_random_command();
            end
        end
        back_to_back = 1'b0;
    endtask

    // Frame sink: random stall before each byte, none in back-to-back runs.
    initial
    begin : frame_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = back_to_back ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                frame_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            frame_ready <= 1'b1;
            @(posedge clk);
            while (!frame_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // Compare every byte transfer against the oldest owed byte.
    always @(posedge clk)
    begin : byte_checker
        out_t want;
        if (rst_n && frame_valid && frame_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h with no frame owed", frame.frame_byte));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (frame.frame_byte !== want.frame_byte)
                    report_mismatch($sformatf("frame_byte %02h, want %02h",
                                              frame.frame_byte, want.frame_byte));
                if (frame.last_byte !== want.last_byte)
                    report_mismatch($sformatf("last_byte %b, want %b",
                                              frame.last_byte, want.last_byte));
                if (frame.applied_speed !== want.applied_speed)
                    report_mismatch($sformatf("applied_speed %0d, want %0d",
                                              frame.applied_speed, want.applied_speed));
                if (frame.applied_steer !== want.applied_steer)
                    report_mismatch($sformatf("applied_steer %0d, want %0d",
                                              frame.applied_steer, want.applied_steer));
                if (frame.started !== want.started)
                    report_mismatch($sformatf("started %b, want %b",
                                              frame.started, want.started));
            end
        end
    end

    // Hang detection: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (frame_valid && frame_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        // Register mirror starts at the reset defaults
        lim_speed = RST_MAX_SPEED;
        lim_steer = RST_MAX_STEER;
        esc_lo = RST_ESC_MIN;
        esc_hi = RST_ESC_MAX;
        steer_lo = RST_STEER_MIN;
        steer_hi = RST_STEER_MAX;
        steer_center = RST_NEUTRAL;
        go_code = RST_START_CODE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_speed_extremes();
        test_steer_extremes();
        test_not_started();
        test_wide_limits();
        test_inverted_limits();
        test_random_traffic();

        wait_frames_done();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: drive_command_to_pwm_frame.f
+incdir+design
design/dcpf_pkg.sv
design/dcpf_cfg.sv
design/dcpf_calc.sv
design/dcpf_ser.sv
design/drive_command_to_pwm_frame.sv
design/dcpf_checker.sv
verif/drive_command_to_pwm_frame_tb.sv
